>>> hdl/tkl_pkg.sv
// Package with the request and response types, the state encoding and the list depth default.
`timescale 1ns / 1ps
package tkl_pkg;

	localparam int LIST_DEPTH_DEF = 8;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_READ   = 2'd2,
		REQ_CLEAR  = 2'd3
	} tkl_req_type_t;

	typedef struct packed {
		tkl_req_type_t      req_type;
		logic [15:0]        item_key;
		logic signed [15:0] item_score;
		logic [2:0]         read_rank;
	} tkl_req_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         insert_position;
		logic               found;
		logic               entry_valid;
		logic [15:0]        entry_key;
		logic signed [15:0] entry_score;
		logic [3:0]         fill_count;
	} tkl_rsp_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} tkl_state_t;

	typedef struct packed {
		logic exec;
	} tkl_cmd_t;

endpackage

>>> hdl/tkl_ctrl.sv
// Controller that runs the request and response handshakes and tells the datapath when to execute.
`timescale 1ns / 1ps
module tkl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tkl_pkg::tkl_cmd_t cmd
);
	import tkl_pkg::*;

	tkl_state_t state_q;
	tkl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		req_stall = 1'b0;
		rsp_valid = 1'b0;
		cmd.exec = 1'b0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.exec = req_valid;
				if (req_valid) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				rsp_valid = 1'b1;
				req_stall = rsp_stall;
				cmd.exec = req_valid && !rsp_stall;
				if (!rsp_stall && !req_valid) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/tkl_dpath.sv
// Datapath holding the sorted entries, the parallel compare and shift, and the response register.
`timescale 1ns / 1ps
module tkl_dpath #(
	parameter int LIST_DEPTH = tkl_pkg::LIST_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tkl_pkg::tkl_cmd_t cmd,
	input  tkl_pkg::tkl_req_t req,
	output tkl_pkg::tkl_rsp_t rsp
);
	import tkl_pkg::*;

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int EXT_W = (CNT_W > 4) ? CNT_W : 4;

	logic [15:0]        key_q   [LIST_DEPTH];
	logic signed [15:0] score_q [LIST_DEPTH];
	logic [15:0]        key_d   [LIST_DEPTH];
	logic signed [15:0] score_d [LIST_DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [EXT_W-1:0]   count_ext;
	logic [LIST_DEPTH-1:0] valid_v;
	logic [LIST_DEPTH-1:0] beats_v;
	logic [LIST_DEPTH-1:0] match_v;
	logic [EXT_W-1:0]   pos;
	logic               ins_ok;
	tkl_rsp_t           rsp_d;
	tkl_rsp_t           rsp_q;

	assign count_ext = EXT_W'(count_q);

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cmp
		assign valid_v[g] = EXT_W'(g) < count_ext;
		assign beats_v[g] = valid_v[g] && (req.item_score > score_q[g]);
		assign match_v[g] = valid_v[g] && (req.item_key == key_q[g]);
	end

	always_comb begin
		pos = count_ext;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (beats_v[i]) begin
				pos = EXT_W'(i);
			end
		end
	end

	assign ins_ok = pos < EXT_W'(LIST_DEPTH);

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_entry
		always_comb begin
			key_d[g] = key_q[g];
			score_d[g] = score_q[g];
			if (req.req_type == REQ_CLEAR) begin
				key_d[g] = '0;
				score_d[g] = '0;
			end else if (req.req_type == REQ_INSERT && ins_ok) begin
				if (EXT_W'(g) == pos) begin
					key_d[g] = req.item_key;
					score_d[g] = req.item_score;
				end else if (EXT_W'(g) > pos) begin
					if (g > 0) begin
						key_d[g] = key_q[(g > 0) ? g - 1 : 0];
						score_d[g] = score_q[(g > 0) ? g - 1 : 0];
					end
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (req.req_type == REQ_CLEAR) begin
			count_d = '0;
		end else if (req.req_type == REQ_INSERT && ins_ok
				&& count_ext < EXT_W'(LIST_DEPTH)) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	always_comb begin
		rsp_d = '0;
		unique case (req.req_type)
			REQ_INSERT: begin
				rsp_d.accepted = ins_ok;
				rsp_d.insert_position = ins_ok ? pos[2:0] : 3'd0;
			end
			REQ_QUERY: begin
				rsp_d.found = |match_v;
			end
			REQ_READ: begin
				for (int i = 0; i < LIST_DEPTH; i++) begin
					if (EXT_W'(req.read_rank) == EXT_W'(i) && valid_v[i]) begin
						rsp_d.entry_valid = 1'b1;
						rsp_d.entry_key = key_q[i];
						rsp_d.entry_score = score_q[i];
					end
				end
			end
			REQ_CLEAR: begin
				rsp_d.accepted = 1'b0;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
		rsp_d.fill_count = 4'(EXT_W'(count_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < LIST_DEPTH; i++) begin
				key_q[i] <= '0;
				score_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			count_q <= count_d;
			for (int i = 0; i < LIST_DEPTH; i++) begin
				key_q[i] <= key_d[i];
				score_q[i] <= score_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> hdl/top_k_sorted_insert_list_core.sv
// Top level of the top-K sorted insertion list: controller, datapath and checks.
`timescale 1ns / 1ps
// The block keeps the best LIST_DEPTH (key, signed score) pairs in descending
// score order and serves insert, membership query, read-by-rank and clear
// requests, each giving one response beat. Every entry is compared against
// the request in parallel and the whole list shifts when the request is
// accepted, so the response appears in the cycle after the request beat.
// The response sits in an output register, and a new request is taken in the
// cycle the previous response is taken, giving one request per cycle when the
// response side does not stall.
module top_k_sorted_insert_list_core #(
	parameter int LIST_DEPTH = tkl_pkg::LIST_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tkl_pkg::tkl_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tkl_pkg::tkl_rsp_t rsp
);
	import tkl_pkg::*;

	tkl_cmd_t cmd;

	tkl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	tkl_dpath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

`ifndef ASSERT_OFF
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("Accepted request produced no response beat.");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.accepted, rsp.found, rsp.entry_valid}))
		else $error("Response carries results of more than one request kind.");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.accepted |-> rsp.insert_position == 3'd0)
		else $error("Insert position set on a response without an insert.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.fill_count) <= 32'(LIST_DEPTH))
		else $error("Fill count beyond the list depth.");
`endif

endmodule
